// ===== rtl/kmp_pkg.sv =====
// Shared constants and types of the keyboard macro player.
package kmp_pkg;

   localparam int STORE_BYTES_DEF  = 1024;
   localparam int HEADER_BYTES_DEF = 2;
   localparam int MAX_ACTIONS_DEF  = 32;

   localparam logic [7:0] MARKER_RESET = 8'd165;
   localparam logic [7:0] ERASED_BYTE  = 8'hFF;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   // Request function codes.
   localparam logic [2:0] FUNC_WRITE  = 3'd0;
   localparam logic [2:0] FUNC_START  = 3'd1;
   localparam logic [2:0] FUNC_TICK   = 3'd2;
   localparam logic [2:0] FUNC_KEY_UP = 3'd3;
   localparam logic [2:0] FUNC_CANCEL = 3'd4;
   localparam logic [2:0] FUNC_STOP   = 3'd5;

   // Result command codes.
   localparam logic [3:0] CMD_STATUS      = 4'd0;
   localparam logic [3:0] CMD_KEY_DOWN    = 4'd1;
   localparam logic [3:0] CMD_KEY_UP      = 4'd2;
   localparam logic [3:0] CMD_MOD_SET     = 4'd3;
   localparam logic [3:0] CMD_MOUSE_DOWN  = 4'd4;
   localparam logic [3:0] CMD_MOUSE_UP    = 4'd5;
   localparam logic [3:0] CMD_WHEEL       = 4'd6;
   localparam logic [3:0] CMD_CONSUMER    = 4'd7;
   localparam logic [3:0] CMD_RELEASE_ALL = 4'd8;

   // Stored action type codes.
   localparam logic [7:0] ACT_END        = 8'd0;
   localparam logic [7:0] ACT_KEY_DOWN   = 8'd1;
   localparam logic [7:0] ACT_KEY_UP     = 8'd2;
   localparam logic [7:0] ACT_MOD_DOWN   = 8'd3;
   localparam logic [7:0] ACT_MOD_UP     = 8'd4;
   localparam logic [7:0] ACT_MOUSE_DOWN = 8'd5;
   localparam logic [7:0] ACT_MOUSE_UP   = 8'd6;
   localparam logic [7:0] ACT_WHEEL      = 8'd7;
   localparam logic [7:0] ACT_CONSUMER   = 8'd8;
   localparam logic [7:0] ACT_DELAY      = 8'd9;

   // Trigger modes.
   localparam logic [1:0] TRIG_ONE_SHOT    = 2'd0;
   localparam logic [1:0] TRIG_HOLD_ABORT  = 2'd1;
   localparam logic [1:0] TRIG_HOLD_FINISH = 2'd2;
   localparam logic [1:0] TRIG_TOGGLE      = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_RUN   = 3'b010,
      MODE_DELAY = 3'b100
   } mode_type;

endpackage

// ===== rtl/keyboard_macro_player.sv =====
// Top level of the keyboard macro player: record store, sequencer and result queue.
module keyboard_macro_player
   import kmp_pkg::*;
#(
   parameter int STORE_BYTES  = STORE_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAX_ACTIONS  = MAX_ACTIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_func,
   input  logic [9:0] req_store_addr,
   input  logic [7:0] req_store_byte,
   input  logic [7:0] req_macro_index,
   input  logic [1:0] req_trigger_mode,
   input  logic [7:0] req_key_index,
   input  logic [15:0] req_now_ms,
   output logic       rsp_valid,
   output logic [3:0] rsp_cmd,
   output logic [7:0] rsp_cmd_param,
   output logic       rsp_busy_res,
   output logic       rsp_delaying,
   output logic       rsp_found,
   output logic [7:0] rsp_owner_key,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   // A request beat is taken when start is high and busy is low. After reset the
   // block first sweeps the whole record store to 0xFF, one byte per cycle, and
   // busy stays high until the sweep is done. Each request then works in two
   // phases. The work phase reads the record store, a memory with one write port
   // and a registered read port, and pushes the commands it makes into a small
   // result queue. A store write, key release, cancel or stop is done in the
   // execute state alone; a start walks the record headers, reading the marker and
   // then the count of each, and a tick reads the type and then the parameter of
   // each action it plays. The play phase then sends the queued commands and a
   // closing status beat, one beat per cycle. Result beats are shown on the
   // rsp_ ports for exactly one cycle, marked by rsp_valid, and the receiver
   // cannot hold them off; rsp_last marks the status beat that ends every
   // request. A new request is taken only once that status beat has gone. The
   // marker register is written through csr_wr_en and csr_wr_data and should
   // only be changed while the block is idle.

   localparam int SAW = $clog2(STORE_BYTES);
   localparam int PW  = $clog2(STORE_BYTES + 512) + 1;
   localparam int XW  = ((SAW > 10) ? SAW : 10) + 1;
   localparam int TW  = $clog2(MAX_ACTIONS + 1);
   localparam int QD  = MAX_ACTIONS + 2;
   localparam int QW  = $clog2(QD + 1);
   localparam int QIW = $clog2(QD);

   typedef enum logic [14:0] {
      S_CLEAR  = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_EXEC   = 15'b000000000000100,
      S_WK_RD  = 15'b000000000001000,
      S_WK_MK  = 15'b000000000010000,
      S_WK_CT  = 15'b000000000100000,
      S_ST2    = 15'b000000001000000,
      S_TK_RD  = 15'b000000010000000,
      S_TK_TY  = 15'b000000100000000,
      S_TK_PA  = 15'b000001000000000,
      S_TK_AB  = 15'b000010000000000,
      S_TK_FIN = 15'b000100000000000,
      S_PLAY   = 15'b001000000000000,
      S_STAT   = 15'b010000000000000,
      S_SPARE  = 15'b100000000000000
   } state_type;

   // Control state.
   state_type state_ff, state_in;
   logic [SAW-1:0] clr_ff, clr_in;
   logic [7:0] marker_ff;
   mode_type mode_ff, mode_in;
   logic [1:0] trig_ff, trig_in;
   logic [7:0] owner_ff, owner_in;
   logic [PW-1:0] base_ff, base_in;
   logic [TW-1:0] apos_ff, apos_in;
   logic [TW-1:0] total_ff, total_in;
   logic kr_ff, kr_in;
   logic sr_ff, sr_in;
   logic [15:0] dstart_ff, dstart_in;
   logic [11:0] dlen_ff, dlen_in;
   logic [7:0] mod_ff, mod_in;
   logic fnd_ff, fnd_in;
   logic [QW-1:0] qn_ff, qn_in;
   logic [QW-1:0] qp_ff, qp_in;
   logic pv_ff, pv_in;

   // Request beat and walk registers.
   logic [2:0] func_ff;
   logic [9:0] addr_ff;
   logic [7:0] sbyte_ff;
   logic [7:0] midx_ff;
   logic [1:0] rtrig_ff;
   logic [7:0] key_ff;
   logic [15:0] now_ff;
   logic [PW-1:0] wpos_ff, wpos_in;
   logic [PW-1:0] seen_ff, seen_in;
   logic [7:0] mk_ff, mk_in;
   logic [7:0] ty_ff, ty_in;

   // Record store.
   logic [7:0] store_mem [STORE_BYTES];
   logic store_we;
   logic [SAW-1:0] store_wa;
   logic [7:0] store_wd;
   logic [PW-1:0] rd_addr;
   logic [7:0] store_rd_ff;
   logic oob_ff;
   logic [7:0] rdv;

   // Result queue.
   logic [11:0] q_mem [QD];
   logic q_push;
   logic [11:0] q_wd;
   logic [11:0] q_rd_ff;

   logic accept;
   logic [XW-1:0] waddr_x;
   logic [PW-1:0] act_addr;
   logic [PW-1:0] nxt_pos;
   logic [7:0] ct_clamp;
   logic [15:0] elapsed;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign rdv      = oob_ff ? ERASED_BYTE : store_rd_ff;
   assign waddr_x  = XW'(addr_ff);
   assign act_addr = base_ff + (PW'(apos_ff) << 1);
   assign nxt_pos  = wpos_ff + PW'(HEADER_BYTES) + (PW'(rdv) << 1);
   assign ct_clamp = (rdv > 8'(MAX_ACTIONS)) ? 8'(MAX_ACTIONS) : rdv;
   assign elapsed  = now_ff - dstart_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mode_in   = mode_ff;
      trig_in   = trig_ff;
      owner_in  = owner_ff;
      base_in   = base_ff;
      apos_in   = apos_ff;
      total_in  = total_ff;
      kr_in     = kr_ff;
      sr_in     = sr_ff;
      dstart_in = dstart_ff;
      dlen_in   = dlen_ff;
      mod_in    = mod_ff;
      fnd_in    = fnd_ff;
      qp_in     = qp_ff;
      pv_in     = 1'b0;
      wpos_in   = wpos_ff;
      seen_in   = seen_ff;
      mk_in     = mk_ff;
      ty_in     = ty_ff;
      store_we  = 1'b0;
      store_wa  = waddr_x[SAW-1:0];
      store_wd  = sbyte_ff;
      rd_addr   = act_addr;
      q_push    = 1'b0;
      q_wd      = {CMD_STATUS, ZERO_BYTE};

      case (state_ff)
         S_CLEAR: begin
            store_we = 1'b1;
            store_wa = clr_ff;
            store_wd = ERASED_BYTE;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SAW'(STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               fnd_in   = 1'b0;
               qp_in    = '0;
               wpos_in  = '0;
               seen_in  = '0;
            end
         end
         S_EXEC: begin
            state_in = S_PLAY;
            case (func_ff)
               FUNC_WRITE: begin
                  store_we = (waddr_x < XW'(STORE_BYTES));
               end
               FUNC_START: begin
                  state_in = S_WK_RD;
               end
               FUNC_TICK: begin
                  if (mode_ff == MODE_RUN) begin
                     state_in = S_TK_RD;
                  end else if (mode_ff == MODE_DELAY &&
                               elapsed >= {4'd0, dlen_ff}) begin
                     mode_in  = MODE_RUN;
                     state_in = S_TK_RD;
                  end
               end
               FUNC_KEY_UP: begin
                  kr_in = 1'b1;
                  if (trig_ff == TRIG_HOLD_ABORT && mode_ff != MODE_IDLE) begin
                     q_push  = 1'b1;
                     q_wd    = {CMD_RELEASE_ALL, ZERO_BYTE};
                     mod_in  = '0;
                     mode_in = MODE_IDLE;
                  end
               end
               FUNC_CANCEL: begin
                  if (mode_ff != MODE_IDLE) begin
                     q_push  = 1'b1;
                     q_wd    = {CMD_RELEASE_ALL, ZERO_BYTE};
                     mod_in  = '0;
                     mode_in = MODE_IDLE;
                  end
               end
               FUNC_STOP: begin
                  sr_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_WK_RD: begin
            rd_addr = wpos_ff;
            if (wpos_ff + PW'(HEADER_BYTES) > PW'(STORE_BYTES)) begin
               state_in = S_PLAY;
            end else begin
               state_in = S_WK_MK;
            end
         end
         S_WK_MK: begin
            mk_in    = rdv;
            rd_addr  = wpos_ff + 1'b1;
            state_in = S_WK_CT;
         end
         S_WK_CT: begin
            state_in = S_PLAY;
            if (mk_ff == ERASED_BYTE || (mk_ff == ZERO_BYTE && rdv == ZERO_BYTE) ||
                (mk_ff != ZERO_BYTE && mk_ff != marker_ff) ||
                nxt_pos > PW'(STORE_BYTES)) begin
               state_in = S_PLAY;
            end else if (mk_ff == marker_ff && seen_ff == PW'(midx_ff)) begin
               fnd_in   = 1'b1;
               total_in = TW'(ct_clamp);
               base_in  = wpos_ff + PW'(HEADER_BYTES);
               state_in = S_ST2;
               if (mode_ff != MODE_IDLE) begin
                  q_push = 1'b1;
                  q_wd   = {CMD_RELEASE_ALL, ZERO_BYTE};
               end
            end else begin
               if (mk_ff == marker_ff) begin
                  seen_in = seen_ff + 1'b1;
               end
               wpos_in  = nxt_pos;
               state_in = S_WK_RD;
            end
         end
         S_ST2: begin
            q_push   = 1'b1;
            q_wd     = {CMD_RELEASE_ALL, ZERO_BYTE};
            mod_in   = '0;
            trig_in  = rtrig_ff;
            owner_in = key_ff;
            apos_in  = '0;
            kr_in    = 1'b0;
            sr_in    = 1'b0;
            mode_in  = MODE_RUN;
            state_in = S_PLAY;
         end
         S_TK_RD: begin
            if (apos_ff < total_ff) begin
               state_in = S_TK_TY;
            end else begin
               state_in = S_TK_FIN;
            end
         end
         S_TK_TY: begin
            ty_in    = rdv;
            rd_addr  = act_addr + 1'b1;
            state_in = S_TK_PA;
         end
         S_TK_PA: begin
            apos_in  = apos_ff + 1'b1;
            state_in = (trig_ff == TRIG_HOLD_ABORT && kr_ff) ? S_TK_AB : S_TK_RD;
            case (ty_ff)
               ACT_END: begin
                  state_in = S_TK_FIN;
               end
               ACT_KEY_DOWN: begin
                  q_push = 1'b1;
                  q_wd   = {CMD_KEY_DOWN, rdv};
               end
               ACT_KEY_UP: begin
                  q_push = 1'b1;
                  q_wd   = {CMD_KEY_UP, rdv};
               end
               ACT_MOD_DOWN: begin
                  mod_in = mod_ff | rdv;
                  q_push = 1'b1;
                  q_wd   = {CMD_MOD_SET, mod_ff | rdv};
               end
               ACT_MOD_UP: begin
                  mod_in = mod_ff & ~rdv;
                  q_push = 1'b1;
                  q_wd   = {CMD_MOD_SET, mod_ff & ~rdv};
               end
               ACT_MOUSE_DOWN: begin
                  q_push = 1'b1;
                  q_wd   = {CMD_MOUSE_DOWN, rdv};
               end
               ACT_MOUSE_UP: begin
                  q_push = 1'b1;
                  q_wd   = {CMD_MOUSE_UP, rdv};
               end
               ACT_WHEEL: begin
                  q_push = 1'b1;
                  q_wd   = {CMD_WHEEL, 7'd0, (rdv == 8'd1)};
               end
               ACT_CONSUMER: begin
                  q_push = 1'b1;
                  q_wd   = {CMD_CONSUMER, rdv};
               end
               ACT_DELAY: begin
                  // Delay length is param times ten, built as 8x + 2x.
                  dstart_in = now_ff;
                  dlen_in   = (12'(rdv) << 3) + (12'(rdv) << 1);
                  mode_in   = MODE_DELAY;
                  state_in  = S_PLAY;
               end
               default: begin
               end
            endcase
         end
         S_TK_AB: begin
            q_push   = 1'b1;
            q_wd     = {CMD_RELEASE_ALL, ZERO_BYTE};
            mod_in   = '0;
            mode_in  = MODE_IDLE;
            state_in = S_PLAY;
         end
         S_TK_FIN: begin
            state_in = S_PLAY;
            if (((trig_ff == TRIG_HOLD_ABORT || trig_ff == TRIG_HOLD_FINISH) && !kr_ff) ||
                (trig_ff == TRIG_TOGGLE && !sr_ff)) begin
               apos_in = '0;
            end else begin
               q_push  = 1'b1;
               q_wd    = {CMD_RELEASE_ALL, ZERO_BYTE};
               mod_in  = '0;
               mode_in = MODE_IDLE;
            end
         end
         S_PLAY: begin
            if (qp_ff < qn_ff) begin
               pv_in = 1'b1;
               qp_in = qp_ff + 1'b1;
            end else begin
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (accept) begin
         qn_in = '0;
      end else if (q_push && qn_ff < QW'(QD)) begin
         qn_in = qn_ff + 1'b1;
      end else begin
         qn_in = qn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         marker_ff <= MARKER_RESET;
         mode_ff   <= MODE_IDLE;
         trig_ff   <= '0;
         owner_ff  <= '0;
         base_ff   <= '0;
         apos_ff   <= '0;
         total_ff  <= '0;
         kr_ff     <= 1'b0;
         sr_ff     <= 1'b0;
         dstart_ff <= '0;
         dlen_ff   <= '0;
         mod_ff    <= '0;
         fnd_ff    <= 1'b0;
         qn_ff     <= '0;
         qp_ff     <= '0;
         pv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         if (csr_wr_en) begin
            marker_ff <= csr_wr_data;
         end
         mode_ff   <= mode_in;
         trig_ff   <= trig_in;
         owner_ff  <= owner_in;
         base_ff   <= base_in;
         apos_ff   <= apos_in;
         total_ff  <= total_in;
         kr_ff     <= kr_in;
         sr_ff     <= sr_in;
         dstart_ff <= dstart_in;
         dlen_ff   <= dlen_in;
         mod_ff    <= mod_in;
         fnd_ff    <= fnd_in;
         qn_ff     <= qn_in;
         qp_ff     <= qp_in;
         pv_ff     <= pv_in;
      end
   end

   // Request beat capture and walk scratch registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         addr_ff  <= req_store_addr;
         sbyte_ff <= req_store_byte;
         midx_ff  <= req_macro_index;
         rtrig_ff <= req_trigger_mode;
         key_ff   <= req_key_index;
         now_ff   <= req_now_ms;
      end
      wpos_ff <= wpos_in;
      seen_ff <= seen_in;
      mk_ff   <= mk_in;
      ty_ff   <= ty_in;
   end

   // Record store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      store_rd_ff <= store_mem[rd_addr[SAW-1:0]];
      oob_ff      <= (rd_addr >= PW'(STORE_BYTES));
   end

   // Result queue.
   always_ff @(posedge clock) begin
      if (q_push && qn_ff < QW'(QD)) begin
         q_mem[qn_ff[QIW-1:0]] <= q_wd;
      end
      q_rd_ff <= q_mem[qp_ff[QIW-1:0]];
   end

   // The status beat follows the last queued command; all beats carry the
   // state as it stands after the request.
   assign rsp_valid     = pv_ff || (state_ff == S_STAT);
   assign rsp_last      = (state_ff == S_STAT);
   assign rsp_cmd       = rsp_last ? CMD_STATUS : q_rd_ff[11:8];
   assign rsp_cmd_param = rsp_last ? ZERO_BYTE : q_rd_ff[7:0];
   assign rsp_busy_res  = (mode_ff != MODE_IDLE);
   assign rsp_delaying  = (mode_ff == MODE_DELAY);
   assign rsp_found     = fnd_ff;
   assign rsp_owner_key = owner_ff;

endmodule

// ===== rtl/kmp_checker.sv =====
// Port-level checker of the keyboard macro player and its bind statement.
module kmp_checker
   import kmp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [3:0] rsp_cmd,
   input logic       rsp_busy_res,
   input logic       rsp_delaying,
   input logic       rsp_last
);

   // The beat marked last is always a status beat.
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_cmd == CMD_STATUS)
      else $error("closing beat is not a status beat");

   // An accepted request makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after an accepted request");

   a_beat_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   // Command beats of one request come back to back up to the status beat.
   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside the beats of one request");

   a_delay_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delaying |-> rsp_busy_res)
      else $error("delaying reported while not busy");

endmodule

bind keyboard_macro_player kmp_checker u_kmp_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_cmd      (rsp_cmd),
   .rsp_busy_res (rsp_busy_res),
   .rsp_delaying (rsp_delaying),
   .rsp_last     (rsp_last)
);

// ===== tb/sv/keyboard_macro_player_tb.sv =====
// Self-checking testbench of the keyboard macro player with its own predictor.
module keyboard_macro_player_tb;
   import kmp_pkg::*;

   // One request beat as the driver presents it.
   typedef struct {
      logic [2:0]  func;
      logic [9:0]  addr;
      logic [7:0]  sbyte;
      logic [7:0]  midx;
      logic [1:0]  trig;
      logic [7:0]  key;
      logic [15:0] now;
   } request_type;

   // One response beat as the block should produce it.
   typedef struct {
      logic [3:0] cmd;
      logic [7:0] param;
      logic       busy_res;
      logic       delaying;
      logic       found;
      logic [7:0] owner;
      logic       last;
   } response_type;

   localparam int MAX_RESULTS = MAX_ACTIONS_DEF + 2;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 100;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_func;
   logic [9:0]  req_store_addr;
   logic [7:0]  req_store_byte;
   logic [7:0]  req_macro_index;
   logic [1:0]  req_trigger_mode;
   logic [7:0]  req_key_index;
   logic [15:0] req_now_ms;
   logic        rsp_valid;
   logic [3:0]  rsp_cmd;
   logic [7:0]  rsp_cmd_param;
   logic        rsp_busy_res;
   logic        rsp_delaying;
   logic        rsp_found;
   logic [7:0]  rsp_owner_key;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   keyboard_macro_player DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_store_addr(req_store_addr),
      .req_store_byte(req_store_byte), .req_macro_index(req_macro_index),
      .req_trigger_mode(req_trigger_mode), .req_key_index(req_key_index),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_cmd(rsp_cmd), .rsp_cmd_param(rsp_cmd_param),
      .rsp_busy_res(rsp_busy_res), .rsp_delaying(rsp_delaying),
      .rsp_found(rsp_found), .rsp_owner_key(rsp_owner_key), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // The clock runs free from time zero with a period of ten units.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Requests waiting for the driver, and responses the block still owes.
   request_type  pending_reqs[$];
   response_type owed_rsps[$];
   int        reqs_queued   = 0;
   int        reqs_accepted = 0;
   int        mismatches    = 0;
   int        cycles        = 0;
   int        gap_left      = 0;
   bit        no_idling     = 1'b0;

   // Predictor state: a shadow of the record store and of the player engine.
   logic [7:0]  shadow_store[STORE_BYTES_DEF];
   logic [7:0]  marker_q;
   mode_type    eng_mode;
   logic [1:0]  trig_kind;
   logic [7:0]  owner_reg;
   int          act_base;
   int          act_pos;
   int          act_total;
   bit          key_gone;
   bit          stop_req;
   logic [15:0] delay_t0;
   logic [15:0] delay_len;
   logic [7:0]  mod_bits;
   logic [3:0]  play_cmd[$];
   logic [7:0]  play_par[$];

   // Time base that the stimulus generator advances on every tick.
   logic [15:0] gen_ms = 16'd0;

   initial begin
      for (int i = 0; i < STORE_BYTES_DEF; i++) shadow_store[i] = ERASED_BYTE;
      marker_q  = MARKER_RESET;
      eng_mode  = MODE_IDLE;
      trig_kind = TRIG_ONE_SHOT;
      owner_reg = 8'd0;
      act_base  = 0;
      act_pos   = 0;
      act_total = 0;
      key_gone  = 1'b0;
      stop_req  = 1'b0;
      delay_t0  = 16'd0;
      delay_len = 16'd0;
      mod_bits  = 8'd0;
   end

   // Every command is logged, but the block holds at most a full action list
   // plus the two release and status beats.
   function automatic void log_cmd(logic [3:0] c, logic [7:0] p);
      if (play_cmd.size() < MAX_RESULTS) begin
         play_cmd.push_back(c);
         play_par.push_back(p);
      end
   endfunction

   // Bytes beyond the store read as erased flash.
   function automatic logic [7:0] store_byte_at(int a);
      return (a < STORE_BYTES_DEF) ? shadow_store[a] : ERASED_BYTE;
   endfunction

   function automatic void drop_all_keys();
      mod_bits = 8'd0;
      log_cmd(CMD_RELEASE_ALL, 8'd0);
   endfunction

   function automatic void stop_engine();
      drop_all_keys();
      eng_mode = MODE_IDLE;
   endfunction

   // Walks the record headers from address zero and returns the address of
   // the idx-th live record, or -1 when the walk ends first.
   function automatic int find_record(logic [7:0] idx);
      int pos;
      int seen;
      int nxt;
      logic [7:0] mk;
      logic [7:0] ct;
      pos  = 0;
      seen = 0;
      while (pos + HEADER_BYTES_DEF <= STORE_BYTES_DEF) begin
         mk = store_byte_at(pos);
         ct = store_byte_at(pos + 1);
         if (mk == ERASED_BYTE) break;
         if (mk == ZERO_BYTE && ct == ZERO_BYTE) break;
         if (mk != ZERO_BYTE && mk != marker_q) break;
         nxt = pos + HEADER_BYTES_DEF + 2 * int'(ct);
         if (nxt > STORE_BYTES_DEF) break;
         if (mk == marker_q) begin
            if (seen == int'(idx)) return pos;
            seen++;
         end
         pos = nxt;
      end
      return -1;
   endfunction

   function automatic bit wants_repeat();
      if (trig_kind == TRIG_HOLD_ABORT || trig_kind == TRIG_HOLD_FINISH) return !key_gone;
      if (trig_kind == TRIG_TOGGLE) return !stop_req;
      return 1'b0;
   endfunction

   // Plays actions until a delay, an end action, a hold-abort release or the end of the list.
   function automatic void play_tick(logic [15:0] now);
      logic [7:0] ty;
      logic [7:0] pa;
      int a;
      if (eng_mode == MODE_IDLE) return;
      if (eng_mode == MODE_DELAY) begin
         if (16'(now - delay_t0) < delay_len) return;
         eng_mode = MODE_RUN;
      end
      while (act_pos < act_total) begin
         a  = act_base + 2 * act_pos;
         ty = store_byte_at(a);
         pa = store_byte_at(a + 1);
         act_pos++;
         if (ty == ACT_END) break;
         case (ty)
            ACT_KEY_DOWN:   log_cmd(CMD_KEY_DOWN, pa);
            ACT_KEY_UP:     log_cmd(CMD_KEY_UP, pa);
            ACT_MOD_DOWN: begin
               mod_bits = mod_bits | pa;
               log_cmd(CMD_MOD_SET, mod_bits);
            end
            ACT_MOD_UP: begin
               mod_bits = mod_bits & ~pa;
               log_cmd(CMD_MOD_SET, mod_bits);
            end
            ACT_MOUSE_DOWN: log_cmd(CMD_MOUSE_DOWN, pa);
            ACT_MOUSE_UP:   log_cmd(CMD_MOUSE_UP, pa);
            ACT_WHEEL:      log_cmd(CMD_WHEEL, (pa == 8'd1) ? 8'd1 : 8'd0);
            ACT_CONSUMER:   log_cmd(CMD_CONSUMER, pa);
            ACT_DELAY: begin
               delay_t0  = now;
               delay_len = 16'(pa) * 16'd10;
               eng_mode  = MODE_DELAY;
               return;
            end
            default: ;
         endcase
         // A released key cuts a hold-abort macro short after any action but an end or a delay.
         if (trig_kind == TRIG_HOLD_ABORT && key_gone) begin
            stop_engine();
            return;
         end
      end
      if (wants_repeat()) act_pos = 0;
      else stop_engine();
   endfunction

   // Works out every response beat that one accepted request causes.
   function automatic void predict_responses(request_type r);
      response_type rsp;
      bit        hit;
      int        at;
      logic [7:0] ct;
      hit = 1'b0;
      play_cmd.delete();
      play_par.delete();
      case (r.func)
         FUNC_WRITE: shadow_store[r.addr] = r.sbyte;
         FUNC_START: begin
            at = find_record(r.midx);
            if (at >= 0) begin
               hit = 1'b1;
               // A start over a running macro cancels it first.
               if (eng_mode != MODE_IDLE) stop_engine();
               drop_all_keys();
               ct = store_byte_at(at + 1);
               if (ct > 8'(MAX_ACTIONS_DEF)) ct = 8'(MAX_ACTIONS_DEF);
               act_base  = at + HEADER_BYTES_DEF;
               trig_kind = r.trig;
               owner_reg = r.key;
               act_pos   = 0;
               act_total = int'(ct);
               key_gone  = 1'b0;
               stop_req  = 1'b0;
               eng_mode  = MODE_RUN;
            end
         end
         FUNC_TICK: play_tick(r.now);
         FUNC_KEY_UP: begin
            key_gone = 1'b1;
            if (trig_kind == TRIG_HOLD_ABORT && eng_mode != MODE_IDLE) stop_engine();
         end
         FUNC_CANCEL: if (eng_mode != MODE_IDLE) stop_engine();
         FUNC_STOP: stop_req = 1'b1;
         default: ;
      endcase
      log_cmd(CMD_STATUS, 8'd0);
      for (int k = 0; k < play_cmd.size(); k++) begin
         rsp.cmd      = play_cmd[k];
         rsp.param    = play_par[k];
         rsp.busy_res = (eng_mode != MODE_IDLE);
         rsp.delaying = (eng_mode == MODE_DELAY);
         rsp.found    = hit;
         rsp.owner    = owner_reg;
         rsp.last     = (k == play_cmd.size() - 1);
         owed_rsps.push_back(rsp);
      end
   endfunction

   task automatic report(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // Driver: presents queued requests, predicts each one at the edge that
   // accepts it, and inserts random idle bursts between beats.
   always @(posedge clock) begin : drive_proc
      logic     next_start;
      request_type cur;
      if (reset) begin
         start            <= 1'b0;
         req_func         <= FUNC_TICK;
         req_store_addr   <= 10'd0;
         req_store_byte   <= 8'd0;
         req_macro_index  <= 8'd0;
         req_trigger_mode <= TRIG_ONE_SHOT;
         req_key_index    <= 8'd0;
         req_now_ms       <= 16'd0;
         gap_left = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            cur.func  = req_func;
            cur.addr  = req_store_addr;
            cur.sbyte = req_store_byte;
            cur.midx  = req_macro_index;
            cur.trig  = req_trigger_mode;
            cur.key   = req_key_index;
            cur.now   = req_now_ms;
            predict_responses(cur);
            reqs_accepted++;
            next_start = 1'b0;
            if (!no_idling && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 11);
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               cur = pending_reqs.pop_front();
               req_func         <= cur.func;
               req_store_addr   <= cur.addr;
               req_store_byte   <= cur.sbyte;
               req_macro_index  <= cur.midx;
               req_trigger_mode <= cur.trig;
               req_key_index    <= cur.key;
               req_now_ms       <= cur.now;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // Monitor: every response beat is checked against the oldest expectation.
   always @(posedge clock) begin : check_proc
      response_type exp_r;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (owed_rsps.size() == 0) begin
            report($sformatf("unexpected beat cmd %0d param %0d", rsp_cmd, rsp_cmd_param));
         end else begin
            exp_r = owed_rsps.pop_front();
            if (rsp_cmd !== exp_r.cmd)
               report($sformatf("cmd %0d, want %0d", rsp_cmd, exp_r.cmd));
            if (rsp_cmd_param !== exp_r.param)
               report($sformatf("cmd_param %0d, want %0d", rsp_cmd_param, exp_r.param));
            if (rsp_busy_res !== exp_r.busy_res)
               report($sformatf("busy_res %0b, want %0b", rsp_busy_res, exp_r.busy_res));
            if (rsp_delaying !== exp_r.delaying)
               report($sformatf("delaying %0b, want %0b", rsp_delaying, exp_r.delaying));
            if (rsp_found !== exp_r.found)
               report($sformatf("found %0b, want %0b", rsp_found, exp_r.found));
            if (rsp_owner_key !== exp_r.owner)
               report($sformatf("owner_key %0d, want %0d", rsp_owner_key, exp_r.owner));
            if (rsp_last !== exp_r.last)
               report($sformatf("last %0b, want %0b", rsp_last, exp_r.last));
         end
      end
   end

   // Queues one request; fields the function does not use get random values
   // so that every input bit toggles.
   task automatic queue_req(logic [2:0] f, logic [9:0] a, logic [7:0] b,
                            logic [7:0] m, logic [1:0] t, logic [7:0] k);
      request_type r;
      r.func  = f;
      r.addr  = a;
      r.sbyte = b;
      r.midx  = m;
      r.trig  = t;
      r.key   = k;
      r.now   = gen_ms;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   task automatic queue_write(int a, logic [7:0] b);
      queue_req(FUNC_WRITE, 10'(a), b, 8'($urandom), 2'($urandom), 8'($urandom));
   endtask

   task automatic queue_cmd(logic [2:0] f, logic [7:0] m, logic [1:0] t, logic [7:0] k);
      queue_req(f, 10'($urandom), 8'($urandom), m, t, k);
   endtask

   task automatic queue_tick(int advance);
      gen_ms = gen_ms + 16'(advance);
      queue_cmd(FUNC_TICK, 8'($urandom), 2'($urandom), 8'($urandom));
   endtask

   // Waits until every queued beat is accepted and answered, then lets the
   // block settle before the next register write.
   task automatic drain();
      while (reqs_accepted != reqs_queued || owed_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_marker(logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      marker_q = v;
   endtask

   // Random phase: lays out a few records at address zero, ends the walk in
   // one of its several ways, then runs macro sessions with some noise.
   task automatic random_phase(int beats);
      int pos;
      int nrec;
      int cnt;
      int stop_at;
      int steps;
      logic [7:0] mk;
      logic [7:0] ty;
      logic [7:0] junk;
      pos     = 0;
      nrec    = $urandom_range(1, 4);
      stop_at = reqs_queued + beats;
      for (int r = 0; r < nrec; r++) begin
         mk  = ($urandom_range(0, 4) == 0) ? ZERO_BYTE : marker_q;
         cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
         queue_write(pos, mk);
         queue_write(pos + 1, 8'(cnt));
         pos += 2;
         for (int i = 0; i < cnt; i++) begin
            ty = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(10, 255))
                                              : 8'($urandom_range(0, 9));
            if (ty == ACT_END && $urandom_range(0, 2) != 0) ty = ACT_KEY_DOWN;
            queue_write(pos, ty);
            queue_write(pos + 1, (ty == ACT_DELAY) ? 8'($urandom_range(0, 5))
                                                   : 8'($urandom));
            pos += 2;
         end
      end
      case ($urandom_range(0, 2))
         0: queue_write(pos, ERASED_BYTE);
         1: begin
            queue_write(pos, ZERO_BYTE);
            queue_write(pos + 1, ZERO_BYTE);
         end
         default: begin
            do junk = 8'($urandom); while (junk == ZERO_BYTE || junk == marker_q ||
                                            junk == ERASED_BYTE);
            queue_write(pos, junk);
         end
      endcase
      while (reqs_queued < stop_at) begin
         case ($urandom_range(0, 19))
            0: queue_write($urandom_range(0, 1023), 8'($urandom));
            1: queue_write($urandom_range(600, 1023), 8'($urandom));
            2: queue_req(3'($urandom_range(6, 7)), 10'($urandom), 8'($urandom),
                         8'($urandom), 2'($urandom), 8'($urandom));
            default: begin
               queue_cmd(FUNC_START,
                         ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, nrec)),
                         2'($urandom), 8'($urandom));
               steps = $urandom_range(1, 8);
               for (int s = 0; s < steps; s++) begin
                  case ($urandom_range(0, 11))
                     0: queue_cmd(FUNC_KEY_UP, 8'($urandom), 2'($urandom), 8'($urandom));
                     1: queue_cmd(FUNC_STOP, 8'($urandom), 2'($urandom), 8'($urandom));
                     2: queue_cmd(FUNC_CANCEL, 8'($urandom), 2'($urandom), 8'($urandom));
                     3: queue_tick($urandom);
                     default: queue_tick($urandom_range(0, 40));
                  endcase
               end
            end
         endcase
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: a small macro with a modifier, the wheel and a
      // zero-length delay, a release that aborts it, a miss on the walk,
      // unknown functions and writes at both ends of the store.
      queue_write(0, MARKER_RESET);
      queue_write(1, 8'd5);
      queue_write(2, ACT_KEY_DOWN);   queue_write(3, 8'd4);
      queue_write(4, ACT_MOD_DOWN);   queue_write(5, 8'hFF);
      queue_write(6, ACT_WHEEL);      queue_write(7, 8'd1);
      queue_write(8, ACT_DELAY);      queue_write(9, 8'd0);
      queue_write(10, ACT_END);       queue_write(11, 8'd0);
      queue_write(1023, 8'd0);
      queue_cmd(FUNC_TICK, 8'd0, TRIG_ONE_SHOT, 8'd0);
      queue_cmd(FUNC_START, 8'd0, TRIG_HOLD_ABORT, 8'hFF);
      queue_tick(1);
      queue_tick(16'hFFFF);
      queue_cmd(FUNC_KEY_UP, 8'd0, TRIG_ONE_SHOT, 8'd0);
      queue_cmd(FUNC_START, 8'hFF, TRIG_TOGGLE, 8'd1);
      queue_cmd(3'd6, 8'd0, TRIG_ONE_SHOT, 8'd0);
      queue_cmd(3'd7, 8'd0, TRIG_ONE_SHOT, 8'd0);
      queue_cmd(FUNC_START, 8'd0, TRIG_TOGGLE, 8'd7);
      queue_cmd(FUNC_STOP, 8'd0, TRIG_ONE_SHOT, 8'd0);
      queue_tick(5);
      queue_cmd(FUNC_CANCEL, 8'd0, TRIG_ONE_SHOT, 8'd0);
      drain();

      // Random phases over the marker extremes and a random marker; the last
      // phase runs without idle gaps.
      write_marker(8'd254);
      random_phase(110);
      drain();
      write_marker(8'd1);
      random_phase(110);
      drain();
      write_marker(8'($urandom_range(2, 253)));
      random_phase(110);
      drain();
      write_marker(MARKER_RESET);
      no_idling = 1'b1;
      random_phase(110);
      drain();

      if (mismatches == 0 && owed_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
